// File: rtl/core/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared widths, result kinds and the result record of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW = 17;
  localparam logic [LenW-1:0] MaxPayloadReset = 17'h10000;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_RSV      = 3'd2,
    KIND_UNMASKED = 3'd3,
    KIND_LONG     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       fin;
    kind_t      kind;
    logic       last;
    logic [7:0] data;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a masked client-to-server byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while its output buffer has room and
// gives at most one result per byte, held in a registered output. Header, length
// and extended length bytes give only error results; mask-key bytes give none but
// the empty frame result of a zero-length frame, on its last mask-key byte. Each
// payload byte gives one unmasked result. The rate is set by the single parse
// state update per byte; a two-entry output buffer keeps input accepted while a
// result waits, until a second result must wait. After any error result the block
// drops all further bytes until reset. max_payload sits at address 0.
`default_nettype none

module websocket_frame_deframer_top
  import wsfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // data_byte
  output logic [7:0]       m_axis_tuser,   // kind[2:0], fin_flag[3], frame_opcode[7:4]
  output logic             m_axis_tlast,   // last_of_frame
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  logic [LenW-1:0] max_payload;
  phase_t          phase, phase_next;
  logic            held_fin, held_fin_next;
  logic [3:0]      held_opcode, held_opcode_next;
  logic [2:0]      bytes_left, bytes_left_next;
  logic [LenW-1:0] length_accum, length_accum_next;
  logic            length_overflow, length_overflow_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [1:0]      mask_pos, mask_pos_next;
  logic [LenW-1:0] payload_left, payload_left_next;
  logic            error_latched, error_latched_next;

  logic            res_valid;
  result_t         res;
  logic            out_valid, skid_valid;
  result_t         out_res, skid_res;
  logic            accept;
  logic [24:0]     ext_shift;
  logic [7:0]      key_byte;
  logic [LenW-1:0] check_len;
  logic            check_ovf;
  logic            length_check;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-LenW){1'b0}}, max_payload} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_payload <= pwdata[LenW-1:0];
    end
  end

  assign s_axis_tready = !skid_valid;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign ext_shift = {length_accum, s_axis_tdata};

  always_comb begin
    case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    held_fin_next        = held_fin;
    held_opcode_next     = held_opcode;
    bytes_left_next      = bytes_left;
    length_accum_next    = length_accum;
    length_overflow_next = length_overflow;
    mask_key_next        = mask_key;
    mask_pos_next        = mask_pos;
    payload_left_next    = payload_left;
    error_latched_next   = error_latched;
    res_valid            = 1'b0;
    res.kind             = KIND_DATA;
    res.data             = 8'd0;
    res.last             = 1'b0;
    check_len            = length_accum;
    check_ovf            = 1'b0;
    length_check         = 1'b0;

    if (!error_latched) begin
      case (phase)
        PH_HEADER: begin
          held_fin_next    = s_axis_tdata[7];
          held_opcode_next = s_axis_tdata[3:0];
          if (s_axis_tdata[6:4] != 3'd0) begin
            res_valid          = 1'b1;
            res.kind           = KIND_RSV;
            error_latched_next = 1'b1;
            phase_next         = PH_HEADER;
          end else begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          length_accum_next    = '0;
          length_overflow_next = 1'b0;
          if (!s_axis_tdata[7]) begin
            res_valid          = 1'b1;
            res.kind           = KIND_UNMASKED;
            error_latched_next = 1'b1;
            phase_next         = PH_HEADER;
          end else if (s_axis_tdata[6:0] == 7'd126) begin
            bytes_left_next = 3'd1;
            phase_next      = PH_EXT;
          end else if (s_axis_tdata[6:0] == 7'd127) begin
            bytes_left_next = 3'd7;
            phase_next      = PH_EXT;
          end else begin
            length_accum_next = {{(LenW-7){1'b0}}, s_axis_tdata[6:0]};
            check_len         = length_accum_next;
            length_check      = 1'b1;
          end
        end
        PH_EXT: begin
          length_overflow_next = length_overflow || (ext_shift[24:LenW] != '0);
          length_accum_next    = ext_shift[LenW-1:0];
          if (bytes_left != 3'd0) begin
            bytes_left_next = bytes_left - 3'd1;
          end else begin
            check_len    = length_accum_next;
            check_ovf    = length_overflow_next;
            length_check = 1'b1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], s_axis_tdata};
          if (mask_pos != 2'd3) begin
            mask_pos_next = mask_pos + 2'd1;
          end else begin
            mask_pos_next = 2'd0;
            if (payload_left == '0) begin
              phase_next = PH_HEADER;
              res_valid  = 1'b1;
              res.kind   = KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mask_pos_next     = mask_pos + 2'd1;
          payload_left_next = payload_left - {{(LenW-1){1'b0}}, 1'b1};
          res_valid         = 1'b1;
          res.kind          = KIND_DATA;
          res.data          = s_axis_tdata ^ key_byte;
          res.last          = (payload_left_next == '0);
          if (payload_left_next == '0) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase

      if (length_check) begin
        if (check_ovf || check_len > max_payload) begin
          res_valid          = 1'b1;
          res.kind           = KIND_LONG;
          error_latched_next = 1'b1;
          phase_next         = PH_HEADER;
        end else begin
          payload_left_next = check_len;
          mask_key_next     = '0;
          mask_pos_next     = 2'd0;
          phase_next        = PH_MASK;
        end
      end
    end

    res.fin    = held_fin_next;
    res.opcode = held_opcode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      held_fin        <= 1'b0;
      held_opcode     <= 4'd0;
      bytes_left      <= 3'd0;
      length_accum    <= '0;
      length_overflow <= 1'b0;
      mask_key        <= '0;
      mask_pos        <= 2'd0;
      payload_left    <= '0;
      error_latched   <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      held_fin        <= held_fin_next;
      held_opcode     <= held_opcode_next;
      bytes_left      <= bytes_left_next;
      length_accum    <= length_accum_next;
      length_overflow <= length_overflow_next;
      mask_key        <= mask_key_next;
      mask_pos        <= mask_pos_next;
      payload_left    <= payload_left_next;
      error_latched   <= error_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else begin
        out_res <= res;
      end
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = {out_res.opcode, out_res.fin, out_res.kind};
  assign m_axis_tlast  = out_res.last;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry held while the output register is empty.");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("Error state cleared without reset.");

  a_error_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:0] != KIND_DATA && m_axis_tuser[2:0] != KIND_EMPTY)
      |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))
    else $error("Error result carries data or a last mark.");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> $stable(m_axis_tuser))
    else $error("Output result changed while stalled with a full buffer.");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives masked frame byte streams into the deframer with random gaps on
// both stream sides and predicts every unmasked payload byte, empty frame
// and error result. The payload limit is set over the register port between
// runs of frames, and the run ends on one malformed frame chosen at random.
// ----------------------------------------------------------------------------

module testbench;
  import wsfd_pkg::*;

  localparam int WatchdogLimit = 2000;

  typedef enum logic [2:0] {
    P_HEADER,
    P_LEN,
    P_EXT,
    P_KEY,
    P_PAYLOAD
  } parse_phase_t;

  typedef enum int {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  class frame_tracker;
    logic [LenW-1:0] max_len;
    parse_phase_t    phase;
    logic            fin;
    logic [3:0]      opcode;
    logic [2:0]      ext_left;
    logic [LenW-1:0] len_acc;
    logic            len_ovf;
    logic [31:0]     key;
    logic [1:0]      key_pos;
    logic [LenW-1:0] pay_left;
    logic            halted;
    result_t         pending_results[$];
    int              errors;

    function new();
      max_len  = MaxPayloadReset;
      phase    = P_HEADER;
      fin      = 1'b0;
      opcode   = 4'h0;
      ext_left = 3'd0;
      len_acc  = '0;
      len_ovf  = 1'b0;
      key      = 32'h0;
      key_pos  = 2'd0;
      pay_left = '0;
      halted   = 1'b0;
      errors   = 0;
    endfunction

    function void push_result(kind_t k, logic [7:0] d, logic l);
      result_t r;
      r.kind   = k;
      r.data   = d;
      r.fin    = fin;
      r.opcode = opcode;
      r.last   = l;
      pending_results.push_back(r);
    endfunction

    function void raise_error(kind_t k);
      halted = 1'b1;
      phase  = P_HEADER;
      push_result(k, 8'h00, 1'b0);
    endfunction

    function void finish_length();
      if (len_ovf || len_acc > max_len) begin
        raise_error(KIND_LONG);
      end else begin
        pay_left = len_acc;
        key      = 32'h0;
        key_pos  = 2'd0;
        phase    = P_KEY;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [24:0] shifted;
      logic [7:0]  key_byte;
      if (halted) return;
      case (phase)
        P_HEADER: begin
          fin    = b[7];
          opcode = b[3:0];
          if (b[6:4] != 3'd0) raise_error(KIND_RSV);
          else phase = P_LEN;
        end
        P_LEN: begin
          if (!b[7]) begin
            raise_error(KIND_UNMASKED);
          end else begin
            len_acc = '0;
            len_ovf = 1'b0;
            if (b[6:0] == 7'd126) begin
              ext_left = 3'd1;
              phase    = P_EXT;
            end else if (b[6:0] == 7'd127) begin
              ext_left = 3'd7;
              phase    = P_EXT;
            end else begin
              len_acc = {10'd0, b[6:0]};
              finish_length();
            end
          end
        end
        P_EXT: begin
          shifted = {len_acc, b};
          if (shifted[24:LenW] != '0) len_ovf = 1'b1;
          len_acc = shifted[LenW-1:0];
          if (ext_left != 3'd0) ext_left = ext_left - 3'd1;
          else finish_length();
        end
        P_KEY: begin
          key = {key[23:0], b};
          if (key_pos != 2'd3) begin
            key_pos = key_pos + 2'd1;
          end else begin
            key_pos = 2'd0;
            if (pay_left == '0) begin
              phase = P_HEADER;
              push_result(KIND_EMPTY, 8'h00, 1'b1);
            end else begin
              phase = P_PAYLOAD;
            end
          end
        end
        P_PAYLOAD: begin
          key_byte = key[8*(3-key_pos) +: 8];
          key_pos  = key_pos + 2'd1;
          pay_left = pay_left - 1'b1;
          if (pay_left == '0) phase = P_HEADER;
          push_result(KIND_DATA, b ^ key_byte, pay_left == '0);
        end
        default: phase = P_HEADER;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: kind %0d, data_byte %0h", got.kind, got.data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("data_byte: expected %0h, got %0h", want.data, got.data);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $error("fin_flag: expected %0d, got %0d", want.fin, got.fin);
        errors++;
      end
      if (got.opcode !== want.opcode) begin
        $error("frame_opcode: expected %0h, got %0h", want.opcode, got.opcode);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker sb;
  bit quiet = 1'b0;
  int sent_bytes = 0;
  int out_stall = 0;
  int idle_cycles = 0;

  websocket_frame_deframer_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic len_form_t pick_form(int len);
    int r;
    r = $urandom_range(0, 9);
    if (len <= 125 && r < 6) return FORM_SHORT;
    if (len <= 65535 && r < 9) return FORM_EXT16;
    return FORM_EXT64;
  endfunction

  always @(posedge clk) begin : ready_pace
    int n;
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      n = pick_gap();
      out_stall = (n > 0) ? n - 1 : 0;
      m_axis_tready <= (n == 0);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.opcode = m_axis_tuser[7:4];
      got.fin    = m_axis_tuser[3];
      got.kind   = kind_t'(m_axis_tuser[2:0]);
      got.last   = m_axis_tlast;
      got.data   = m_axis_tdata;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_byte(b);
    sent_bytes++;
  endtask

  task automatic send_head(input logic fin, input logic [3:0] op, input logic [63:0] len,
                           input len_form_t form);
    push_byte({fin, 3'b000, op});
    case (form)
      FORM_SHORT: push_byte({1'b1, len[6:0]});
      FORM_EXT16: begin
        push_byte(8'hFE);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte(8'hFF);
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input int len,
                            input len_form_t form, input logic [31:0] key);
    send_head(fin, op, 64'(len), form);
    for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    for (int n = 0; n < len; n++) push_byte(8'($urandom()));
  endtask

  task automatic random_frame(input int limit);
    int r;
    int cap;
    int len;
    r   = $urandom_range(0, 99);
    cap = (r < 50) ? 8 : (r < 85) ? 40 : 300;
    if (cap > limit) cap = limit;
    len = $urandom_range(0, cap);
    send_frame(1'($urandom()), 4'($urandom()), len, pick_form(len), $urandom());
  endtask

  task automatic random_run(input int budget, input int limit);
    int start;
    quiet = ($urandom_range(0, 3) == 0);
    start = sent_bytes;
    while (sent_bytes - start < budget) random_frame(limit);
    quiet = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_limit();
    logic [31:0] word;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'd0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    word = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (word !== {15'd0, sb.max_len}) begin
      $error("max_payload: expected %0d, got %0d", sb.max_len, word);
      sb.errors++;
    end
  endtask

  task automatic set_limit(input logic [LenW-1:0] v);
    logic [14:0] junk;
    junk = 15'($urandom());
    apb_write(3'd0, {junk, v});
    sb.max_len = v;
    check_limit();
  endtask

  // The block halts for good after an error, so only one malformed frame ends the run.
  task automatic send_broken_frame();
    logic        fin;
    logic [3:0]  op;
    logic [63:0] len;
    int          lim;
    fin = 1'($urandom());
    op  = 4'($urandom());
    lim = sb.max_len;
    case ($urandom_range(0, 3))
      0: push_byte({fin, 3'($urandom_range(1, 7)), op});
      1: begin
        push_byte({fin, 3'b000, op});
        push_byte({1'b0, 7'($urandom())});
      end
      2: begin
        len = $urandom_range(lim + 1, ($urandom_range(0, 1) != 0) ? 125 : 65536);
        send_head(fin, op, len, pick_form(int'(len)));
      end
      default: begin
        len = 64'($urandom_range(0, 40)) | (64'd1 << $urandom_range(17, 63))
              | {$urandom(), 32'd0};
        send_head(fin, op, len, FORM_EXT64);
      end
    endcase
    repeat (24) push_byte(8'($urandom()));
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_limit();

    for (int op = 0; op < 16; op++)
      send_frame(op[0], op[3:0], 0, len_form_t'(op % 3), $urandom());
    send_frame(1'b1, 4'h1, 1, FORM_SHORT, 32'h0000_0000);
    send_frame(1'b0, 4'h2, 4, FORM_SHORT, 32'hFFFF_FFFF);
    send_frame(1'b1, 4'h8, 5, FORM_EXT16, $urandom());
    send_frame(1'b1, 4'h9, 9, FORM_EXT64, $urandom());
    send_frame(1'b1, 4'hA, 125, FORM_SHORT, $urandom());
    random_run(50, sb.max_len);
    drain();

    apb_write(3'd4, $urandom());
    check_limit();
    set_limit('0);
    random_run(40, 0);
    drain();

    set_limit(17'd126);
    send_frame(1'b1, 4'h2, 126, FORM_EXT16, $urandom());
    random_run(30, 126);
    drain();

    set_limit(MaxPayloadReset);
    random_run(20, 65536);
    drain();

    set_limit(17'($urandom_range(1, 400)));
    random_run(30, sb.max_len);
    drain();

    set_limit(17'($urandom_range(0, 124)));
    random_run(20, sb.max_len);
    send_broken_frame();
    drain();

    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
